/* rtl/lgge_pkg.sv */
// Package for the life grid generation engine: word types, request codes,
// register indexes, reset values and the B3/S23 cell rule.
// No dependencies.
package lgge_pkg;

  localparam int CFG_W       = 7;
  localparam int COL_W       = 6;
  localparam int ROW_IDX_W   = 6;
  localparam int ROW_BITS_W  = 64;
  localparam int GEN_W       = 16;
  localparam int SWEEP_CNT_W = CFG_W + 1;

  localparam int MAX_WIDTH_DEF  = 64;
  localparam int MAX_HEIGHT_DEF = 64;

  localparam logic [CFG_W-1:0] GRID_WIDTH_RST  = 7'd64;
  localparam logic [CFG_W-1:0] GRID_HEIGHT_RST = 7'd64;

  localparam logic [1:0] REQ_WRITE   = 2'd0;
  localparam logic [1:0] REQ_ADVANCE = 2'd1;
  localparam logic [1:0] REQ_READ    = 2'd2;

  localparam logic REG_GRID_WIDTH  = 1'b0;
  localparam logic REG_GRID_HEIGHT = 1'b1;

  localparam logic STATUS_DONE  = 1'b0;
  localparam logic STATUS_RANGE = 1'b1;

  localparam logic [3:0] BIRTH_COUNT = 4'd3;
  localparam logic [3:0] SURVIVE_LOW = 4'd2;

  typedef struct packed {
    logic [1:0]           req_type;
    logic [COL_W-1:0]     col_index;
    logic [ROW_IDX_W-1:0] row_index;
    logic                 cell_value;
  } req_t;

  typedef struct packed {
    logic [ROW_BITS_W-1:0] row_bits;
    logic                  status;
    logic [GEN_W-1:0]      generation_count;
  } rsp_t;

  // Next state of one cell from its 3x3 neighbourhood (index 1 of mid is the cell).
  function automatic logic life_cell(logic [2:0] up, logic [2:0] mid, logic [2:0] dn);
    logic [3:0] n;
    n = 4'(up[0]) + 4'(up[1]) + 4'(up[2]) + 4'(mid[0]) + 4'(mid[2])
      + 4'(dn[0]) + 4'(dn[1]) + 4'(dn[2]);
    if (mid[1]) begin
      return (n == SURVIVE_LOW) || (n == BIRTH_COUNT);
    end else begin
      return n == BIRTH_COUNT;
    end
  endfunction

endpackage

/* rtl/life_grid_generation_engine.sv */
// Life grid engine top level: cell grid memory, request sequencer and
// row-parallel generation sweep. Depends on lgge_pkg.
//
//   channel  direction  handshake               word
//   req      in         req_valid / req_stall   lgge_pkg::req_t
//   rsp      out        rsp_valid / rsp_stall   lgge_pkg::rsp_t
//   cfg      in         cfg_valid / cfg_ready   cfg_index, cfg_data
//
// Write cell and read row first read the row from grid memory, then modify
// and write it back or register the result. Bad coordinates answer straight from idle.
// Advance sweeps the active height: the sweep reads one row a cycle through
// a three-row window, writing each row back once the row below it is in the window.
// After reset a clearing pass zeroes every row of the grid; no request
// is taken meanwhile. req_stall holds while busy or while a result waits.
module life_grid_generation_engine #(
  parameter int MAX_WIDTH  = lgge_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = lgge_pkg::MAX_HEIGHT_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      req_valid,
  output logic                      req_stall,
  input  lgge_pkg::req_t            req,
  output logic                      rsp_valid,
  input  logic                      rsp_stall,
  output lgge_pkg::rsp_t            rsp,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic                      cfg_index,
  input  logic [lgge_pkg::CFG_W-1:0] cfg_data
);

  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int HCMP_W = ($clog2(MAX_HEIGHT + 1) > lgge_pkg::CFG_W) ?
                          $clog2(MAX_HEIGHT + 1) : lgge_pkg::CFG_W;
  localparam int CNT_W  = lgge_pkg::SWEEP_CNT_W;

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_RMW   = 5'b00100,
    S_READ  = 5'b01000,
    S_SWEEP = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  logic [lgge_pkg::CFG_W-1:0] grid_width;
  logic [lgge_pkg::CFG_W-1:0] grid_height;
  logic [lgge_pkg::GEN_W-1:0] gen;
  logic [ROW_W-1:0]           clr_addr;
  logic [CNT_W-1:0]           cnt;
  lgge_pkg::req_t             held;
  logic [MAX_WIDTH-1:0]       above;
  logic [MAX_WIDTH-1:0]       cur;

  logic [MAX_WIDTH-1:0] mem [MAX_HEIGHT];
  logic [MAX_WIDTH-1:0] rd_data;
  logic [ROW_W-1:0]     mem_raddr;
  logic [ROW_W-1:0]     mem_waddr;
  logic [MAX_WIDTH-1:0] mem_wdata;
  logic                 mem_we;

  logic [lgge_pkg::CFG_W-1:0] act_w;
  logic [lgge_pkg::CFG_W-1:0] act_h;
  logic [HCMP_W-1:0]          h_wide;
  logic [CNT_W-1:0]           h_ext;
  logic [MAX_WIDTH-1:0]       col_mask;

  logic                 accept;
  logic                 below_ok;
  logic                 sweep_we;
  logic                 sweep_done;
  logic [MAX_WIDTH-1:0] below_raw;
  logic [MAX_WIDTH+1:0] pad_a;
  logic [MAX_WIDTH+1:0] pad_c;
  logic [MAX_WIDTH+1:0] pad_b;
  logic [MAX_WIDTH-1:0] new_row;
  logic [MAX_WIDTH-1:0] set_row;

  logic           rsp_load;
  lgge_pkg::rsp_t rsp_next;

  // Sizes beyond the built grid act as the built grid.
  assign h_wide = HCMP_W'(grid_height);
  assign act_h  = (h_wide > HCMP_W'(MAX_HEIGHT)) ? lgge_pkg::CFG_W'(MAX_HEIGHT) : grid_height;
  assign act_w  = (grid_width > lgge_pkg::CFG_W'(MAX_WIDTH)) ?
                  lgge_pkg::CFG_W'(MAX_WIDTH) : grid_width;
  assign h_ext  = CNT_W'(act_h);

  always_comb begin
    for (int i = 0; i < MAX_WIDTH; i++) begin
      col_mask[i] = lgge_pkg::CFG_W'(i) < act_w;
    end
  end

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= lgge_pkg::GRID_WIDTH_RST;
      grid_height <= lgge_pkg::GRID_HEIGHT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        lgge_pkg::REG_GRID_WIDTH:  grid_width  <= cfg_data;
        lgge_pkg::REG_GRID_HEIGHT: grid_height <= cfg_data;
        default: ;
      endcase
    end
  end

  assign req_stall = (state != S_IDLE) || (rsp_valid && rsp_stall);
  assign accept    = req_valid && !req_stall;

  // Sweep window: rd_data holds row cnt-1, cur row cnt-2, above row cnt-3.
  assign below_ok   = (cnt != '0) && (cnt <= h_ext);
  assign below_raw  = below_ok ? rd_data : '0;
  assign sweep_we   = (cnt >= CNT_W'(2)) && (cnt < h_ext + CNT_W'(2));
  assign sweep_done = cnt == h_ext + CNT_W'(1);

  assign pad_a = {1'b0, above & col_mask, 1'b0};
  assign pad_c = {1'b0, cur & col_mask, 1'b0};
  assign pad_b = {1'b0, below_raw & col_mask, 1'b0};

  always_comb begin
    for (int x = 0; x < MAX_WIDTH; x++) begin
      new_row[x] = col_mask[x] && lgge_pkg::life_cell(pad_a[x +: 3], pad_c[x +: 3], pad_b[x +: 3]);
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_WIDTH; i++) begin
      set_row[i] = (lgge_pkg::COL_W'(i) == held.col_index) ? held.cell_value : rd_data[i];
    end
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clr_addr;
    mem_wdata = '0;
    mem_raddr = (state == S_SWEEP) ? ROW_W'(cnt) : ROW_W'(req.row_index);
    unique case (state)
      S_CLEAR: mem_we = 1'b1;
      S_RMW: begin
        mem_we    = 1'b1;
        mem_waddr = ROW_W'(held.row_index);
        mem_wdata = set_row;
      end
      S_SWEEP: begin
        mem_we    = sweep_we;
        mem_waddr = ROW_W'(cnt - CNT_W'(2));
        mem_wdata = (cur & ~col_mask) | new_row;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[mem_raddr];
  end

  always_comb begin
    state_next = state;
    rsp_load   = 1'b0;
    rsp_next   = '{row_bits: '0, status: lgge_pkg::STATUS_DONE, generation_count: gen};
    unique case (state)
      S_CLEAR: begin
        if (clr_addr == ROW_W'(MAX_HEIGHT - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          unique case (req.req_type)
            lgge_pkg::REQ_WRITE: begin
              if ((lgge_pkg::CFG_W'(req.col_index) < act_w) &&
                  (lgge_pkg::CFG_W'(req.row_index) < act_h)) begin
                state_next = S_RMW;
              end else begin
                rsp_load        = 1'b1;
                rsp_next.status = lgge_pkg::STATUS_RANGE;
              end
            end
            lgge_pkg::REQ_ADVANCE: state_next = S_SWEEP;
            lgge_pkg::REQ_READ: begin
              if (lgge_pkg::CFG_W'(req.row_index) < act_h) begin
                state_next = S_READ;
              end else begin
                rsp_load        = 1'b1;
                rsp_next.status = lgge_pkg::STATUS_RANGE;
              end
            end
            default: rsp_load = 1'b1;
          endcase
        end
      end
      S_RMW: begin
        rsp_load   = 1'b1;
        state_next = S_IDLE;
      end
      S_READ: begin
        rsp_load          = 1'b1;
        rsp_next.row_bits = lgge_pkg::ROW_BITS_W'(rd_data & col_mask);
        state_next        = S_IDLE;
      end
      S_SWEEP: begin
        if (sweep_done) begin
          rsp_load                  = 1'b1;
          rsp_next.generation_count = gen + lgge_pkg::GEN_W'(1);
          state_next                = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      cnt       <= '0;
      gen       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + ROW_W'(1);
      end
      if (state == S_SWEEP) begin
        cnt <= cnt + CNT_W'(1);
        if (sweep_done) begin
          gen <= gen + lgge_pkg::GEN_W'(1);
        end
      end else begin
        cnt <= '0;
      end
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Payload registers: request hold, sweep window and result word.
  always_ff @(posedge clk) begin
    if (accept) begin
      held <= req;
    end
    if (state == S_SWEEP) begin
      above <= cur;
      cur   <= below_raw;
    end else begin
      above <= '0;
      cur   <= '0;
    end
    if (rsp_load) begin
      rsp <= rsp_next;
    end
  end

`ifndef SYNTH
  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    !((state == S_IDLE) && mem_we))
    else $error("grid memory written while idle");

  a_hold_when_full: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_stall) |-> req_stall)
    else $error("request taken while a result waits");

  a_gen_step: assert property (@(posedge clk) disable iff (rst)
    ((state == S_SWEEP) && sweep_done) |=>
      (gen == lgge_pkg::GEN_W'($past(gen) + lgge_pkg::GEN_W'(1))))
    else $error("generation count did not advance after sweep");

  a_clear_blocks: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> req_stall)
    else $error("request taken during clearing pass");
`endif

endmodule

/* bench/tb_life_grid_generation_engine.sv */
// Self-checking bench for life_grid_generation_engine: a directed table, then random
// seed/advance/read phases; each answer is checked against a shadow Life grid or a table entry.
// Depends on lgge_pkg and the engine RTL.
module tb_life_grid_generation_engine;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int BORN_AT      = 3;
  localparam int KEPT_AT      = 2;
  localparam int PLAN_LEN     = 36;
  localparam int ITEM_TARGET  = 1500;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int DRAIN_CYCLES = 80;
  localparam int HOLD_CYCLES  = 400;

  typedef struct {
    bit                         is_cfg;
    logic                       cfg_sel;
    logic [lgge_pkg::CFG_W-1:0] cfg_val;
    lgge_pkg::req_t             word;
    bit                         typed;
    lgge_pkg::rsp_t             want;
  } plan_row_t;

  logic                       clk;
  logic                       rst = 1'b1;
  logic                       req_valid = 1'b0;
  logic                       req_stall;
  lgge_pkg::req_t             req = '0;
  logic                       rsp_valid;
  logic                       rsp_stall = 1'b0;
  lgge_pkg::rsp_t             rsp;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic                       cfg_index = 1'b0;
  logic [lgge_pkg::CFG_W-1:0] cfg_data = '0;

  // shadow of the engine
  logic [63:0]                shadow_grid [64];
  logic [lgge_pkg::CFG_W-1:0] cols_set = lgge_pkg::GRID_WIDTH_RST;
  logic [lgge_pkg::CFG_W-1:0] rows_set = lgge_pkg::GRID_HEIGHT_RST;
  logic [15:0]                gen_count = '0;

  lgge_pkg::rsp_t pending_answers [$];
  int   mismatches = 0;
  int   items_sent = 0;
  int   burst_left = 0;
  bit   cfg_live = 1'b0;
  bit   hold_wanted = 1'b0;

  life_grid_generation_engine u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    for (int i = 0; i < 64; i++) begin
      shadow_grid[i] = '0;
    end
  end

  function automatic logic [63:0] width_mask(int unsigned cols);
    if (cols >= 64) begin
      return '1;
    end
    return (64'd1 << cols) - 64'd1;
  endfunction

  function automatic int live_at(logic [63:0] r, int x);
    if (x < 0 || x > 63) begin
      return 0;
    end
    return int'(r[x]);
  endfunction

  // One generation over the active area; cells outside it are kept as stored.
  function automatic void step_generation(int unsigned cols, int unsigned rows);
    logic [63:0] keep;
    logic [63:0] above;
    logic [63:0] cur;
    logic [63:0] below;
    logic [63:0] fresh;
    int          n;
    keep  = width_mask(cols);
    above = '0;
    for (int y = 0; y < int'(rows); y++) begin
      cur   = shadow_grid[y] & keep;
      below = (y + 1 < int'(rows)) ? (shadow_grid[y + 1] & keep) : '0;
      fresh = '0;
      for (int x = 0; x < int'(cols); x++) begin
        n = live_at(above, x - 1) + live_at(above, x) + live_at(above, x + 1)
          + live_at(cur, x - 1) + live_at(cur, x + 1)
          + live_at(below, x - 1) + live_at(below, x) + live_at(below, x + 1);
        fresh[x] = (n == BORN_AT) || (cur[x] && n == KEPT_AT);
      end
      shadow_grid[y] = (shadow_grid[y] & ~keep) | fresh;
      above = cur;
    end
    gen_count = gen_count + 16'd1;
  endfunction

  function automatic lgge_pkg::rsp_t grid_answer(lgge_pkg::req_t w);
    lgge_pkg::rsp_t r;
    int unsigned    cols;
    int unsigned    rows;
    cols = (cols_set > 64) ? 64 : cols_set;
    rows = (rows_set > 64) ? 64 : rows_set;
    r = '0;
    r.status = lgge_pkg::STATUS_DONE;
    case (w.req_type)
      lgge_pkg::REQ_WRITE: begin
        if (w.col_index >= cols || w.row_index >= rows) begin
          r.status = lgge_pkg::STATUS_RANGE;
        end else begin
          shadow_grid[w.row_index][w.col_index] = w.cell_value;
        end
      end
      lgge_pkg::REQ_ADVANCE: begin
        step_generation(cols, rows);
      end
      lgge_pkg::REQ_READ: begin
        if (w.row_index >= rows) begin
          r.status = lgge_pkg::STATUS_RANGE;
        end else begin
          r.row_bits = shadow_grid[w.row_index] & width_mask(cols);
        end
      end
      default: ;
    endcase
    r.generation_count = gen_count;
    return r;
  endfunction

  function automatic lgge_pkg::req_t make_req(logic [1:0] kind, int col, int row, logic val);
    lgge_pkg::req_t r;
    r.req_type   = kind;
    r.col_index  = lgge_pkg::COL_W'(col);
    r.row_index  = lgge_pkg::ROW_IDX_W'(row);
    r.cell_value = val;
    return r;
  endfunction

  function automatic plan_row_t cfg_row(logic sel, logic [lgge_pkg::CFG_W-1:0] val);
    plan_row_t p;
    p.is_cfg  = 1'b1;
    p.cfg_sel = sel;
    p.cfg_val = val;
    p.word    = '0;
    p.typed   = 1'b0;
    p.want    = '0;
    return p;
  endfunction

  function automatic plan_row_t op_row(logic [1:0] kind, int col, int row, logic val);
    plan_row_t p;
    p.is_cfg  = 1'b0;
    p.cfg_sel = 1'b0;
    p.cfg_val = '0;
    p.word    = make_req(kind, col, row, val);
    p.typed   = 1'b0;
    p.want    = '0;
    return p;
  endfunction

  function automatic plan_row_t known_row(logic [1:0] kind, int col, int row, logic val,
                                          logic [63:0] bits, logic st, logic [15:0] gen);
    plan_row_t p;
    p = op_row(kind, col, row, val);
    p.typed = 1'b1;
    p.want.row_bits = bits;
    p.want.status = st;
    p.want.generation_count = gen;
    return p;
  endfunction

  // Present one request word, possibly idling first at the start of a burst, and hold it until taken.
  task automatic offer(input lgge_pkg::req_t w);
    int gap;
    gap = 0;
    if (cfg_live) begin
      cfg_valid <= 1'b0;
      cfg_live = 1'b0;
    end
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 10);
    end
    burst_left--;
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= w;
    @(posedge clk);
    while (req_stall !== 1'b0) @(posedge clk);
  endtask

  task automatic issue(input lgge_pkg::req_t w, input bit typed, input lgge_pkg::rsp_t fixed);
    lgge_pkg::rsp_t ans;
    offer(w);
    ans = grid_answer(w);
    pending_answers.push_back(typed ? fixed : ans);
    items_sent++;
  endtask

  // Write a size register once the engine is idle; back-to-back writes keep valid up.
  task automatic set_register(input logic sel, input logic [lgge_pkg::CFG_W-1:0] val);
    if (!cfg_live) begin
      req_valid <= 1'b0;
      while (pending_answers.size() != 0) @(posedge clk);
    end
    cfg_valid <= 1'b1;
    cfg_index <= sel;
    cfg_data  <= val;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    cfg_live = 1'b1;
    if (sel == lgge_pkg::REG_GRID_WIDTH) begin
      cols_set = val;
    end else begin
      rows_set = val;
    end
  endtask

  task automatic flag_mismatch(string what, logic [63:0] want, logic [63:0] got);
    mismatches++;
    $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
  endtask

  task automatic check_answer(lgge_pkg::rsp_t got);
    lgge_pkg::rsp_t want;
    if (pending_answers.size() == 0) begin
      mismatches++;
      $display("%0t: word with no answer pending, expected none, got %h", $time, got);
      return;
    end
    want = pending_answers.pop_front();
    if (got.row_bits !== want.row_bits) begin
      flag_mismatch("row_bits", want.row_bits, got.row_bits);
    end
    if (got.status !== want.status) begin
      flag_mismatch("status", 64'(want.status), 64'(got.status));
    end
    if (got.generation_count !== want.generation_count) begin
      flag_mismatch("generation_count", 64'(want.generation_count),
                    64'(got.generation_count));
    end
  endtask

  initial begin : answer_side
    int   seg_left;
    int   mode;
    int   hold_left;
    bit   held_once;
    logic stall_next;
    seg_left  = 0;
    mode      = 0;
    hold_left = 0;
    held_once = 1'b0;
    forever begin
      @(posedge clk);
      if (rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
        check_answer(rsp);
      end
      if (hold_wanted && !held_once) begin
        held_once = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        stall_next = 1'b1;
      end else begin
        if (seg_left == 0) begin
          mode     = $urandom_range(0, 2);
          seg_left = $urandom_range(5, 60);
        end
        seg_left--;
        case (mode)
          0: stall_next = 1'b0;
          1: stall_next = ($urandom_range(0, 3) == 0);
          default: stall_next = ($urandom_range(0, 3) != 0);
        endcase
      end
      rsp_stall <= stall_next;
    end
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  initial begin : stimulus
    plan_row_t      plan [PLAN_LEN];
    int             w_set;
    int             h_set;
    int             aw;
    int             ah;
    int             ops;
    int             pick;
    int             seeds;
    int             k;
    lgge_pkg::req_t word;
    plan = '{
      known_row(lgge_pkg::REQ_READ, 0, 0, 1'b0, 64'd0, lgge_pkg::STATUS_DONE, 16'd0),
      known_row(lgge_pkg::REQ_READ, 63, 63, 1'b1, 64'd0, lgge_pkg::STATUS_DONE, 16'd0),
      known_row(lgge_pkg::REQ_WRITE, 0, 0, 1'b1, 64'd0, lgge_pkg::STATUS_DONE, 16'd0),
      known_row(lgge_pkg::REQ_WRITE, 63, 63, 1'b1, 64'd0, lgge_pkg::STATUS_DONE, 16'd0),
      known_row(lgge_pkg::REQ_READ, 0, 63, 1'b0, 64'h8000_0000_0000_0000,
                lgge_pkg::STATUS_DONE, 16'd0),
      op_row(lgge_pkg::REQ_WRITE, 1, 0, 1'b1),
      op_row(lgge_pkg::REQ_WRITE, 2, 0, 1'b1),
      op_row(lgge_pkg::REQ_ADVANCE, 0, 0, 1'b0),
      op_row(lgge_pkg::REQ_READ, 0, 0, 1'b0),
      known_row(REQ_UNUSED, 63, 63, 1'b1, 64'd0, lgge_pkg::STATUS_DONE, 16'd1),
      op_row(lgge_pkg::REQ_WRITE, 1, 1, 1'b0),
      cfg_row(lgge_pkg::REG_GRID_WIDTH, 7'd127),
      cfg_row(lgge_pkg::REG_GRID_HEIGHT, 7'd127),
      op_row(lgge_pkg::REQ_READ, 0, 63, 1'b0),
      cfg_row(lgge_pkg::REG_GRID_WIDTH, 7'd8),
      cfg_row(lgge_pkg::REG_GRID_HEIGHT, 7'd5),
      known_row(lgge_pkg::REQ_WRITE, 8, 0, 1'b1, 64'd0, lgge_pkg::STATUS_RANGE, 16'd1),
      known_row(lgge_pkg::REQ_WRITE, 3, 5, 1'b1, 64'd0, lgge_pkg::STATUS_RANGE, 16'd1),
      known_row(lgge_pkg::REQ_READ, 0, 5, 1'b0, 64'd0, lgge_pkg::STATUS_RANGE, 16'd1),
      op_row(lgge_pkg::REQ_WRITE, 7, 4, 1'b1),
      op_row(lgge_pkg::REQ_WRITE, 6, 4, 1'b1),
      op_row(lgge_pkg::REQ_WRITE, 7, 3, 1'b1),
      op_row(lgge_pkg::REQ_ADVANCE, 0, 0, 1'b0),
      op_row(lgge_pkg::REQ_READ, 0, 4, 1'b0),
      cfg_row(lgge_pkg::REG_GRID_WIDTH, 7'd0),
      cfg_row(lgge_pkg::REG_GRID_HEIGHT, 7'd0),
      known_row(lgge_pkg::REQ_WRITE, 0, 0, 1'b1, 64'd0, lgge_pkg::STATUS_RANGE, 16'd2),
      known_row(lgge_pkg::REQ_READ, 0, 0, 1'b0, 64'd0, lgge_pkg::STATUS_RANGE, 16'd2),
      op_row(lgge_pkg::REQ_ADVANCE, 0, 0, 1'b0),
      cfg_row(lgge_pkg::REG_GRID_WIDTH, 7'd1),
      cfg_row(lgge_pkg::REG_GRID_HEIGHT, 7'd1),
      op_row(lgge_pkg::REQ_ADVANCE, 0, 0, 1'b0),
      op_row(lgge_pkg::REQ_READ, 0, 0, 1'b0),
      cfg_row(lgge_pkg::REG_GRID_WIDTH, 7'd64),
      cfg_row(lgge_pkg::REG_GRID_HEIGHT, 7'd64),
      op_row(lgge_pkg::REQ_READ, 0, 63, 1'b0)
    };

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < PLAN_LEN; i++) begin
      if (plan[i].is_cfg) begin
        set_register(plan[i].cfg_sel, plan[i].cfg_val);
      end else begin
        issue(plan[i].word, plan[i].typed, plan[i].want);
      end
    end

    // let the answer side back up once the random traffic starts
    hold_wanted = 1'b1;

    while (items_sent < ITEM_TARGET) begin
      k = $urandom_range(0, 19);
      if (k == 0) begin
        w_set = $urandom_range(0, 1);
        h_set = $urandom_range(0, 3);
      end else if (k <= 2) begin
        w_set = 64;
        h_set = 64;
      end else if (k == 3) begin
        w_set = $urandom_range(65, 127);
        h_set = $urandom_range(65, 127);
      end else if (k <= 5) begin
        w_set = $urandom_range(2, 64);
        h_set = $urandom_range(2, 64);
      end else begin
        w_set = $urandom_range(2, 12);
        h_set = $urandom_range(2, 12);
      end
      set_register(lgge_pkg::REG_GRID_WIDTH, lgge_pkg::CFG_W'(w_set));
      set_register(lgge_pkg::REG_GRID_HEIGHT, lgge_pkg::CFG_W'(h_set));
      aw = (w_set > 64) ? 64 : w_set;
      ah = (h_set > 64) ? 64 : h_set;

      // seed a random soup before letting it evolve
      if (aw > 0 && ah > 0 && $urandom_range(0, 3) != 0) begin
        seeds = $urandom_range(3, (aw * ah < 40) ? aw * ah : 40);
        repeat (seeds) begin
          issue(make_req(lgge_pkg::REQ_WRITE, $urandom_range(0, aw - 1),
                         $urandom_range(0, ah - 1), $urandom_range(0, 3) != 0), 1'b0, '0);
        end
      end

      ops = $urandom_range(15, 60);
      repeat (ops) begin
        pick = $urandom_range(0, 99);
        if (pick < 35 && aw > 0 && ah > 0) begin
          issue(make_req(lgge_pkg::REQ_WRITE, $urandom_range(0, aw - 1),
                         $urandom_range(0, ah - 1), $urandom_range(0, 4) < 3), 1'b0, '0);
        end else if (pick < 55) begin
          issue(make_req(lgge_pkg::REQ_ADVANCE, $urandom_range(0, 63), $urandom_range(0, 63),
                         $urandom_range(0, 1)), 1'b0, '0);
          if ($urandom_range(0, 2) == 0) begin
            for (int y = 0; y < ah && y < 16; y++) begin
              issue(make_req(lgge_pkg::REQ_READ, $urandom_range(0, 63), y, 1'b0), 1'b0, '0);
            end
          end
        end else if (pick < 90 && ah > 0) begin
          issue(make_req(lgge_pkg::REQ_READ, $urandom_range(0, 63), $urandom_range(0, ah - 1),
                         $urandom_range(0, 1)), 1'b0, '0);
        end else begin
          word = 15'($urandom);
          issue(word, 1'b0, '0);
        end
      end
    end

    req_valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
